FILE: hw/rtl/first_substring_match_macros.svh
// ----------------------------------------------------------------------------
// First substring match: assertion macros
// Shorthand for clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_SUBSTRING_MATCH_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_MACROS_SVH

// Assertion that is off while reset is held.
`define FSUBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked through reset as well.
`define FSUBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fsubm_pkg.sv
// ----------------------------------------------------------------------------
// First substring match: shared package
// Constants, register indexes and internal structs of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsubm_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_TEXT_DEF    = 65536;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_LEN_W   = 5;
    localparam int MATCH_IDX_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [PAT_LEN_W-1:0]  pattern_length;
    } pattern_cfg_t;

    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } win_ctrl_t;

    typedef struct packed {
        logic                 hit;
        logic [PAT_LEN_W-1:0] len;
    } win_status_t;

endpackage

FILE: hw/rtl/fsubm_text_if.sv
// ----------------------------------------------------------------------------
// First substring match: text channel
// Valid/ready channel carrying one text byte and its last marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsubm_text_if import fsubm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/fsubm_result_if.sv
// ----------------------------------------------------------------------------
// First substring match: result channel
// Valid/ready channel carrying the search result of one text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsubm_result_if import fsubm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [MATCH_IDX_W-1:0] match_index;
    logic                   too_long;

    modport source (output valid, output found, output match_index, output too_long,
                    input ready);
    modport sink   (input valid, input found, input match_index, input too_long,
                    output ready);
endinterface

FILE: hw/rtl/fsubm_cfg_if.sv
// ----------------------------------------------------------------------------
// First substring match: configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsubm_cfg_if import fsubm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fsubm_cfg_regs.sv
// ----------------------------------------------------------------------------
// First substring match: configuration registers
// Holds the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsubm_cfg_regs import fsubm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fsubm_cfg_if.sink    cfg,
    output pattern_cfg_t pat
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [PAT_LEN_W-1:0]  pattern_length_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg.data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg.data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg.data[PAT_LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign pat.pattern_low    = pattern_low_reg;
    assign pat.pattern_high   = pattern_high_reg;
    assign pat.pattern_length = pattern_length_reg;

endmodule

FILE: hw/rtl/fsubm_window.sv
// ----------------------------------------------------------------------------
// First substring match: byte window and compare
// Keeps the most recent text bytes and compares the window ending at the
// current byte with the pattern, all positions in parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsubm_window import fsubm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  win_ctrl_t    ctrl,
    input  pattern_cfg_t pat,
    output win_status_t  status
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    logic [BYTE_W-1:0]    recent_reg [DEPTH];
    logic [BYTE_W-1:0]    window     [MAX_PATTERN];
    logic [BYTE_W-1:0]    pat_bytes  [MAX_PATTERN];
    logic [PAT_LEN_W-1:0] len;
    logic                 mismatch;

    assign len = (pat.pattern_length > PAT_LEN_W'(MAX_PATTERN)) ?
                 PAT_LEN_W'(MAX_PATTERN) : pat.pattern_length;

    assign window[0] = ctrl.data;

    genvar gi;
    generate
        for (gi = 1; gi < MAX_PATTERN; gi++)
        begin : g_window
            assign window[gi] = recent_reg[gi-1];
        end
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_pat
            if (gi < 8)
            begin : g_low
                assign pat_bytes[gi] = pat.pattern_low[BYTE_W*gi +: BYTE_W];
            end
            else
            begin : g_high
                assign pat_bytes[gi] = pat.pattern_high[BYTE_W*(gi-8) +: BYTE_W];
            end
        end
    endgenerate

    // Pattern byte j lines up with the byte len-1-j places back.
    always_comb
    begin
        mismatch = 1'b0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (PAT_LEN_W'(j) < len)
            begin
                if (window[IDX_W'(len - PAT_LEN_W'(j) - PAT_LEN_W'(1))] != pat_bytes[j])
                begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    assign status.hit = !mismatch;
    assign status.len = len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (ctrl.shift)
        begin
            recent_reg[0] <= ctrl.data;
            for (int i = 1; i < DEPTH; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

endmodule

FILE: hw/rtl/first_substring_match.sv
// ----------------------------------------------------------------------------
// First substring match: top level
// Searches a byte stream for the first occurrence of a configured pattern
// and reports it on the byte marked last.
//
//   channel  modport  per transaction
//   text     sink     text_byte, last_byte
//   result   source   found, match_index, too_long
//   cfg      sink     index, data (register write)
//
// One text byte is taken every cycle unless the input stalls; the window compare
// sits between the input register and the result register, so the last byte
// passes the input register and its result is then loaded into the result register.
// Input stalls only while a result waits unaccepted and the next last byte
// sits in the input register behind it. Reset clears the pattern, the window
// and the text state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_substring_match import fsubm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    fsubm_text_if.sink      text,
    fsubm_result_if.source  result,
    fsubm_cfg_if.sink       cfg
);

    localparam int POS_SAT = MAX_TEXT + MAX_PATTERN;
    localparam int POS_W   = $clog2(POS_SAT + 1);

    pattern_cfg_t pat;
    win_ctrl_t    win_ctrl;
    win_status_t  win_status;

    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      in_byte_reg;
    logic                   in_last_reg;

    logic [POS_W-1:0]       pos_reg;
    logic                   seen_reg;
    logic [MATCH_IDX_W-1:0] start_reg;

    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [MATCH_IDX_W-1:0] out_index_reg;
    logic                   out_too_long_reg;

    logic                   advance;
    logic                   room;
    logic [POS_W-1:0]       pos_inc;
    logic [POS_W-1:0]       len_ext;
    logic [POS_W-1:0]       start;
    logic                   start_ok;
    logic                   new_match;
    logic [POS_W-1:0]       pos_next;
    logic                   seen_next;
    logic [MATCH_IDX_W-1:0] start_next;
    logic                   too_long_next;

    fsubm_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pat   (pat)
    );

    fsubm_window #(.MAX_PATTERN(MAX_PATTERN)) u_window
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .pat    (pat),
        .status (win_status)
    );

    assign advance    = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign text.ready = !in_valid_reg || advance;

    assign win_ctrl.shift = advance;
    assign win_ctrl.clear = advance && in_last_reg;
    assign win_ctrl.data  = in_byte_reg;

    always_comb
    begin
        room      = pos_reg < POS_W'(POS_SAT);
        pos_inc   = pos_reg + POS_W'(1);
        len_ext   = POS_W'(win_status.len);
        start     = pos_inc - len_ext;
        start_ok  = (32'(start) < 32'(MAX_TEXT)) && (32'(start) <= 32'hFFFF);
        new_match = room && !seen_reg &&
                    ((win_status.len == '0) ||
                     ((pos_inc >= len_ext) && win_status.hit && start_ok));
        pos_next   = room ? pos_inc : pos_reg;
        seen_next  = seen_reg || new_match;
        start_next = start_reg;
        if (new_match)
        begin
            start_next = (win_status.len == '0) ? '0 : MATCH_IDX_W'(start);
        end
        too_long_next = pos_next > POS_W'(MAX_TEXT);
    end

    // Input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.text_byte;
            in_last_reg <= text.last_byte;
        end
    end

    // Text state: advance per byte, drop after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                pos_reg   <= '0;
                seen_reg  <= 1'b0;
                start_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                seen_reg  <= seen_next;
                start_reg <= start_next;
            end
        end
    end

    // Result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_found_reg    <= seen_next;
            out_index_reg    <= seen_next ? start_next : '0;
            out_too_long_reg <= too_long_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = out_found_reg;
    assign result.match_index = out_index_reg;
    assign result.too_long    = out_too_long_reg;

endmodule

FILE: hw/rtl/fsubm_checker.sv
// ----------------------------------------------------------------------------
// First substring match: port checker
// Watches the top-level ports for result timing and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_substring_match_macros.svh"

module fsubm_checker import fsubm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   text_valid,
    input logic                   text_ready,
    input logic                   text_last_byte,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic                   result_found,
    input logic [MATCH_IDX_W-1:0] result_match_index,
    input logic                   result_too_long
);

    // Hold a stalled result transaction.
    `FSUBM_ASSERT(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result_found) && $stable(result_match_index) && $stable(result_too_long), "result changed while stalled")

    `FSUBM_ASSERT(a_index_zero, clk, rst_n, result_valid && !result_found |-> result_match_index == '0, "match_index nonzero without a match")

    `FSUBM_ASSERT(a_result_after_last, clk, rst_n, $rose(result_valid) |-> $past(text_valid && text_ready && text_last_byte, 2), "result without a last byte two cycles before")

    `FSUBM_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !result_valid, "result valid during reset")

endmodule

bind first_substring_match fsubm_checker u_fsubm_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .text_valid         (text.valid),
    .text_ready         (text.ready),
    .text_last_byte     (text.last_byte),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_found       (result.found),
    .result_match_index (result.match_index),
    .result_too_long    (result.too_long)
);

FILE: verif/first_substring_match_test.sv
// ----------------------------------------------------------------------------
// First substring match: block-level test
// Streams texts into the block and checks each search result against a
// cycle-free software copy of the search. Covers the empty pattern, patterns
// longer than the text, overlong pattern lengths, overlapping candidates and
// several pattern settings, with random idle cycles on the text and result
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_substring_match_test;
    import fsubm_pkg::*;

    class text_search_checker;
        typedef struct {
            logic                   found;
            logic [MATCH_IDX_W-1:0] match_index;
            logic                   too_long;
        } search_result_t;

        logic [CFG_DATA_W-1:0]  pat_lo;
        logic [CFG_DATA_W-1:0]  pat_hi;
        logic [PAT_LEN_W-1:0]   pat_len;
        logic [BYTE_W-1:0]      history [MAX_PATTERN_DEF-1];
        int unsigned            position;
        bit                     seen;
        logic [MATCH_IDX_W-1:0] first_start;
        search_result_t         expected_results [$];
        int                     errors;
        int                     texts_checked;
        int                     hits;
        int                     overflows;

        function new();
            pat_lo = '0;
            pat_hi = '0;
            pat_len = '0;
            errors = 0;
            texts_checked = 0;
            hits = 0;
            overflows = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (history[k])
                history[k] = '0;
            position = 0;
            seen = 1'b0;
            first_start = '0;
        endfunction

        function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_LOW:    pat_lo = data;
                REG_PATTERN_HIGH:   pat_hi = data;
                REG_PATTERN_LENGTH: pat_len = data[PAT_LEN_W-1:0];
                default:            ;
            endcase
        endfunction

        function int unsigned active_length();
            return (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
        endfunction

        function logic [BYTE_W-1:0] pattern_byte(int unsigned j);
            if (j < 8)
                return pat_lo[8*j +: 8];
            return pat_hi[8*(j-8) +: 8];
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            int unsigned    m;
            int unsigned    start;
            int unsigned    d;
            int unsigned    j;
            bit             same;
            logic [BYTE_W-1:0] t;
            search_result_t r;
            m = active_length();
            if (position < MAX_TEXT_DEF + MAX_PATTERN_DEF)
            begin
                if (!seen)
                begin
                    if (m == 0)
                    begin
                        seen = 1'b1;
                        first_start = '0;
                    end
                    else if (position + 1 >= m)
                    begin
                        start = position + 1 - m;
                        same = 1'b1;
                        for (j = 0; j < m; j++)
                        begin
                            d = m - 1 - j;
                            t = (d == 0) ? b : history[d-1];
                            if (t != pattern_byte(j))
                                same = 1'b0;
                        end
                        if (same && start < MAX_TEXT_DEF && start <= 16'hFFFF)
                        begin
                            seen = 1'b1;
                            first_start = start[MATCH_IDX_W-1:0];
                        end
                    end
                end
                position++;
            end
            for (j = MAX_PATTERN_DEF - 2; j > 0; j--)
                history[j] = history[j-1];
            history[0] = b;
            if (last)
            begin
                r.found = seen;
                r.match_index = seen ? first_start : '0;
                r.too_long = (position > MAX_TEXT_DEF);
                expected_results.push_back(r);
                clear_text();
            end
        endfunction

        function void check_result(logic found, logic [MATCH_IDX_W-1:0] match_index,
                                   logic too_long);
            search_result_t e;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no text pending, found %0b index %0d", $time,
                         found, match_index);
                return;
            end
            e = expected_results.pop_front();
            texts_checked++;
            if (e.found)
                hits++;
            if (e.too_long)
                overflows++;
            if (found !== e.found)
            begin
                errors++;
                $display("%0t: found mismatch, expected %0b actual %0b", $time, e.found, found);
            end
            if (match_index !== e.match_index)
            begin
                errors++;
                $display("%0t: match_index mismatch, expected %0d actual %0d", $time,
                         e.match_index, match_index);
            end
            if (too_long !== e.too_long)
            begin
                errors++;
                $display("%0t: too_long mismatch, expected %0b actual %0b", $time,
                         e.too_long, too_long);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    fsubm_text_if   text ();
    fsubm_result_if result ();
    fsubm_cfg_if    cfg ();

    first_substring_match u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    text_search_checker search_sb = new();
    logic [BYTE_W-1:0]  text_buf [$];
    bit                 gaps_on = 1'b1;
    int                 items_sent = 0;
    int                 settings_used = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #(8_000_000);
        $display("%0t: timeout, %0d results outstanding", $time,
                 search_sb.expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            search_sb.check_result(result.found, result.match_index, result.too_long);
        result.ready <= !(gaps_on && $urandom_range(99) < 38);
    end

    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        while (gaps_on && $urandom_range(99) < 38)
        begin
            text.valid <= 1'b0;
            @(posedge clk);
        end
        text.valid     <= 1'b1;
        text.text_byte <= b;
        text.last_byte <= last;
        do
            @(posedge clk);
        while (!text.ready);
        search_sb.take_byte(b, last);
        items_sent++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic wait_idle();
        text.valid <= 1'b0;
        while (search_sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        search_sb.write_register(idx, data);
    endtask

    task automatic write_pattern(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                                 logic [PAT_LEN_W-1:0] len);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(int mode);
        int unsigned m;
        m = search_sb.active_length();
        if (m == 0)
            m = MAX_PATTERN_DEF;
        case (mode)
            1:       return search_sb.pattern_byte($urandom_range(1));
            2:       return search_sb.pattern_byte($urandom_range(m - 1));
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pattern_word(int kind);
        logic [CFG_DATA_W-1:0] w;
        case (kind)
            1:
            begin
                for (int k = 0; k < 8; k++)
                    w[8*k +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
            end
            2:       w = '0;
            3:       w = '1;
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    initial
    begin
        int unsigned len;
        int unsigned m;
        int unsigned at;
        int          mode;
        int          kind;
        int          phase;
        logic [PAT_LEN_W-1:0] plen;

        rst_n          <= 1'b0;
        text.valid     <= 1'b0;
        text.text_byte <= '0;
        text.last_byte <= 1'b0;
        cfg.valid      <= 1'b0;
        cfg.index      <= REG_PATTERN_LOW;
        cfg.data       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern straight out of reset
        text_buf = '{8'hFF};
        send_text();

        wait_idle();
        write_pattern(64'h0000_0000_0043_4241, 64'h0, 5'd3);
        text_buf = '{8'h41, 8'h42};
        send_text();
        text_buf = '{8'h00, 8'hFF, 8'h41, 8'h42, 8'h43};
        send_text();
        text_buf = '{8'h41, 8'h42, 8'h43};
        send_text();

        wait_idle();
        write_pattern('1, '1, 5'd16);
        text_buf.delete();
        repeat (16)
            text_buf.push_back(8'hFF);
        send_text();

        phase = 0;
        while (items_sent < 1130)
        begin
            wait_idle();
            kind = $urandom_range(5);
            case ($urandom_range(7))
                0:       plen = 5'd0;
                1:       plen = 5'd1;
                2:       plen = 5'd16;
                3:       plen = PAT_LEN_W'($urandom_range(17, 31));
                default: plen = PAT_LEN_W'($urandom_range(1, 16));
            endcase
            if (phase == 0)
                write_pattern('0, '0, 5'd31);
            else
                write_pattern(pick_pattern_word(kind), pick_pattern_word(kind), plen);
            gaps_on = (phase != 3);
            repeat (8)
            begin
                mode = $urandom_range(2);
                len = ($urandom_range(99) < 85) ? $urandom_range(1, 20)
                                                : $urandom_range(21, 60);
                text_buf.delete();
                repeat (len)
                    text_buf.push_back(pick_byte(mode));
                m = search_sb.active_length();
                if (m > 0 && len >= m && $urandom_range(99) < 60)
                begin
                    at = $urandom_range(len - m);
                    for (int unsigned j = 0; j < m; j++)
                        text_buf[at + j] = search_sb.pattern_byte(j);
                end
                send_text();
            end
            phase++;
        end
        gaps_on = 1'b1;

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d bytes in %0d texts under %0d pattern settings;",
                 items_sent, search_sb.texts_checked, settings_used);
        $display("%0d texts matched, %0d ran past the length limit.",
                 search_sb.hits, search_sb.overflows);
        if (search_sb.errors == 0 && search_sb.expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
